// ===== design/apt_pkg.sv =====
`timescale 1ns / 1ps

package apt_pkg;

  localparam int NUM_CHAN  = 13;
  localparam int CHAN_W    = 4;
  localparam int CNT_W     = 8;
  localparam int TMR_W     = 8;
  localparam int STARTUP_W = 10;
  localparam int MEM_W     = CNT_W + TMR_W;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 10;

  localparam logic [CHAN_W-1:0] CHAN_END  = CHAN_W'(NUM_CHAN);
  localparam logic [CHAN_W-1:0] LAST_CHAN = CHAN_W'(NUM_CHAN - 1);

  // Channels below this index load the secondary timer only in treatment.
  localparam logic [CHAN_W-1:0] FIRST_FREE_CHAN = 4'd5;

  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_STARTUP_TICKS   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SECONDARY_DELAY = 1'b1;

  localparam logic [STARTUP_W-1:0] STARTUP_TICKS_RST   = 10'd100;
  localparam logic [TMR_W-1:0]     SECONDARY_DELAY_RST = 8'd65;

  typedef struct packed {
    logic [CHAN_W-1:0] idx;
    logic [CNT_W-1:0]  count;
    logic [TMR_W-1:0]  timer;
    logic              pending;
    logic              check;
    logic              treat;
    logic [TMR_W-1:0]  delay;
  } chan_in_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [TMR_W-1:0] timer;
    logic             pending;
    logic             fire;
    logic             sec_fire;
  } chan_out_t;

  function automatic logic [CNT_W-1:0] chan_limit(input logic [CHAN_W-1:0] idx);
    logic [CNT_W-1:0] lim;
    case (idx)
      4'd0:    lim = 8'd60;
      4'd1:    lim = 8'd60;
      4'd2:    lim = 8'd60;
      4'd3:    lim = 8'd70;
      4'd4:    lim = 8'd40;
      4'd5:    lim = 8'd10;
      4'd6:    lim = 8'd20;
      4'd7:    lim = 8'd20;
      4'd8:    lim = 8'd10;
      4'd9:    lim = 8'd20;
      4'd10:   lim = 8'd20;
      4'd11:   lim = 8'd20;
      4'd12:   lim = 8'd200;
      default: lim = 8'd0;
    endcase
    return lim;
  endfunction

endpackage

// ===== design/apt_ram.sv =====
`timescale 1ns / 1ps

module apt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 13
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/apt_chan_calc.sv =====
`timescale 1ns / 1ps

module apt_chan_calc (
  input  apt_pkg::chan_in_t  chan_in,
  output apt_pkg::chan_out_t chan_out
);
  import apt_pkg::*;

  logic [CNT_W-1:0] limit;
  logic [CNT_W-1:0] cnt_inc;
  logic [TMR_W-1:0] tmr_mid;
  logic             load_ok;

  assign limit   = chan_limit(chan_in.idx);
  assign cnt_inc = chan_in.count + CNT_W'(1);
  assign load_ok = (chan_in.idx >= FIRST_FREE_CHAN) || chan_in.treat;

  always_comb begin
    chan_out.count    = chan_in.count;
    chan_out.timer    = chan_in.timer;
    chan_out.pending  = chan_in.pending;
    chan_out.fire     = 1'b0;
    chan_out.sec_fire = 1'b0;
    tmr_mid           = chan_in.timer;
    if (chan_in.check) begin
      if (chan_in.pending) begin
        if (chan_in.count < limit) begin
          chan_out.count = cnt_inc;
          if (cnt_inc == limit) begin
            chan_out.fire = 1'b1;
            if (load_ok && (chan_in.delay != '0)) begin
              tmr_mid = chan_in.delay;
            end
          end
        end
      end else begin
        chan_out.count = '0;
      end
      // The secondary timer counts down in the same tick that loads it.
      chan_out.timer = tmr_mid;
      if (tmr_mid != '0) begin
        chan_out.timer    = tmr_mid - TMR_W'(1);
        chan_out.sec_fire = (tmr_mid == TMR_W'(1));
      end
    end else begin
      chan_out.pending = 1'b0;
      chan_out.count   = '0;
    end
  end

endmodule

// ===== design/alarm_persistence_timer_bank_core.sv =====
`timescale 1ns / 1ps

// Bank of 13 alarm channels with persistence counters and secondary timers.
// An update transaction (latching one channel's pending bit) and a tick that
// only advances the startup counter each give their result in the cycle
// after acceptance. A tick after startup scans the bank: the per-channel
// counter and secondary timer live in one memory with a registered read
// port, and the sequencer reads, updates and writes back one channel per
// cycle. Every transaction returns exactly one result; the next input is
// taken while that result waits, as long as the output register is free at
// that edge. The memory needs no clearing pass after reset; per-entry valid
// bits make unwritten entries read as zero.
module alarm_persistence_timer_bank_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_cmd,
  input  logic [apt_pkg::CHAN_W-1:0]       in_channel,
  input  logic                             in_pending,
  input  logic [apt_pkg::NUM_CHAN-1:0]     in_check_mask,
  input  logic                             in_in_treatment,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [apt_pkg::NUM_CHAN-1:0]     out_alarm_fired,
  output logic [apt_pkg::NUM_CHAN-1:0]     out_secondary_fired,
  output logic [apt_pkg::NUM_CHAN-1:0]     out_active_mask,
  output logic                             out_startup_done,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [apt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [apt_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import apt_pkg::*;

  typedef enum logic {ST_IDLE, ST_SCAN} state_t;

  state_t                 state_r, state_nxt;
  logic [STARTUP_W-1:0]   startup_ticks_r;
  logic [TMR_W-1:0]       sec_delay_r;
  logic [STARTUP_W-1:0]   startup_cnt_r, startup_cnt_nxt;
  logic [NUM_CHAN-1:0]    pending_r, pending_nxt;
  logic [NUM_CHAN-1:0]    active_r, active_nxt;
  logic [NUM_CHAN-1:0]    mem_vld_r, mem_vld_nxt;
  logic [NUM_CHAN-1:0]    mask_r, mask_nxt;
  logic                   treat_r, treat_nxt;
  logic [NUM_CHAN-1:0]    fired_r, fired_nxt;
  logic [NUM_CHAN-1:0]    sec_r, sec_nxt;
  logic [CHAN_W-1:0]      rd_idx_r, rd_idx_nxt;
  logic [CHAN_W-1:0]      proc_idx_r;
  logic                   proc_vld_r;
  logic                   out_valid_r, out_valid_nxt;
  logic [NUM_CHAN-1:0]    out_alarm_r, out_alarm_nxt;
  logic [NUM_CHAN-1:0]    out_sec_r, out_sec_nxt;
  logic [NUM_CHAN-1:0]    out_active_r, out_active_nxt;
  logic                   out_done_r, out_done_nxt;

  logic                   in_accept;
  logic                   startup_busy;
  logic [STARTUP_W-1:0]   startup_inc;
  logic                   rd_en;
  logic                   wr_en;
  logic [MEM_W-1:0]       rd_data;
  logic [MEM_W-1:0]       wr_data;
  chan_in_t               calc_in;
  chan_out_t              calc_out;

  assign in_stall     = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign in_accept    = in_valid && !in_stall;
  assign cfg_ready    = 1'b1;
  assign startup_busy = startup_cnt_r < startup_ticks_r;
  assign startup_inc  = startup_cnt_r + STARTUP_W'(1);

  apt_ram #(
    .WIDTH (MEM_W),
    .DEPTH (NUM_CHAN)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (proc_idx_r),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_idx_r),
    .rd_data (rd_data)
  );

  // An entry never written since reset reads as zero.
  always_comb begin
    calc_in.idx     = proc_idx_r;
    calc_in.count   = mem_vld_r[proc_idx_r] ? rd_data[MEM_W-1:TMR_W] : '0;
    calc_in.timer   = mem_vld_r[proc_idx_r] ? rd_data[TMR_W-1:0] : '0;
    calc_in.pending = pending_r[proc_idx_r];
    calc_in.check   = mask_r[proc_idx_r];
    calc_in.treat   = treat_r;
    calc_in.delay   = sec_delay_r;
  end

  apt_chan_calc u_calc (
    .chan_in  (calc_in),
    .chan_out (calc_out)
  );

  assign wr_data = {calc_out.count, calc_out.timer};

  always_comb begin
    state_nxt       = state_r;
    startup_cnt_nxt = startup_cnt_r;
    pending_nxt     = pending_r;
    active_nxt      = active_r;
    mem_vld_nxt     = mem_vld_r;
    mask_nxt        = mask_r;
    treat_nxt       = treat_r;
    fired_nxt       = fired_r;
    sec_nxt         = sec_r;
    rd_idx_nxt      = rd_idx_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_alarm_nxt   = out_alarm_r;
    out_sec_nxt     = out_sec_r;
    out_active_nxt  = out_active_r;
    out_done_nxt    = out_done_r;
    rd_en           = 1'b0;
    wr_en           = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_cmd == CMD_UPDATE) begin
            if (in_channel < CHAN_END) begin
              pending_nxt[in_channel] = in_pending;
            end
            out_valid_nxt  = 1'b1;
            out_alarm_nxt  = '0;
            out_sec_nxt    = '0;
            out_active_nxt = active_r;
            out_done_nxt   = !startup_busy;
          end else if (startup_busy) begin
            startup_cnt_nxt = startup_inc;
            out_valid_nxt   = 1'b1;
            out_alarm_nxt   = '0;
            out_sec_nxt     = '0;
            out_active_nxt  = active_r;
            out_done_nxt    = !(startup_inc < startup_ticks_r);
          end else begin
            state_nxt  = ST_SCAN;
            rd_idx_nxt = '0;
            mask_nxt   = in_check_mask;
            treat_nxt  = in_in_treatment;
            fired_nxt  = '0;
            sec_nxt    = '0;
          end
        end
      end
      ST_SCAN: begin
        if (rd_idx_r != CHAN_END) begin
          rd_en      = 1'b1;
          rd_idx_nxt = rd_idx_r + CHAN_W'(1);
        end
        if (proc_vld_r) begin
          wr_en                   = 1'b1;
          mem_vld_nxt[proc_idx_r] = 1'b1;
          pending_nxt[proc_idx_r] = calc_out.pending;
          fired_nxt[proc_idx_r]   = calc_out.fire;
          sec_nxt[proc_idx_r]     = calc_out.sec_fire;
          if (calc_out.fire) begin
            active_nxt[proc_idx_r] = 1'b1;
          end
          if (proc_idx_r == LAST_CHAN) begin
            state_nxt      = ST_IDLE;
            out_valid_nxt  = 1'b1;
            out_alarm_nxt  = fired_nxt;
            out_sec_nxt    = sec_nxt;
            out_active_nxt = active_nxt;
            out_done_nxt   = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      startup_ticks_r <= STARTUP_TICKS_RST;
      sec_delay_r     <= SECONDARY_DELAY_RST;
      startup_cnt_r   <= '0;
      pending_r       <= '0;
      active_r        <= '0;
      mem_vld_r       <= '0;
      rd_idx_r        <= '0;
      proc_vld_r      <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      startup_cnt_r <= startup_cnt_nxt;
      pending_r     <= pending_nxt;
      active_r      <= active_nxt;
      mem_vld_r     <= mem_vld_nxt;
      rd_idx_r      <= rd_idx_nxt;
      proc_vld_r    <= rd_en;
      out_valid_r   <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_STARTUP_TICKS:   startup_ticks_r <= cfg_data[STARTUP_W-1:0];
          REG_SECONDARY_DELAY: sec_delay_r     <= cfg_data[TMR_W-1:0];
          default: begin
          end
        endcase
      end
    end
    proc_idx_r   <= rd_idx_r;
    mask_r       <= mask_nxt;
    treat_r      <= treat_nxt;
    fired_r      <= fired_nxt;
    sec_r        <= sec_nxt;
    out_alarm_r  <= out_alarm_nxt;
    out_sec_r    <= out_sec_nxt;
    out_active_r <= out_active_nxt;
    out_done_r   <= out_done_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_alarm_fired     = out_alarm_r;
  assign out_secondary_fired = out_sec_r;
  assign out_active_mask     = out_active_r;
  assign out_startup_done    = out_done_r;

`ifndef SYNTH
  // A channel that fires its alarm is reported active in the same result.
  a_fired_active: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_alarm_r & ~out_active_r) == '0))
    else $error("alarm fired for a channel not marked active");

  // No channel is evaluated before the startup delay has elapsed.
  a_startup_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_done_r) |-> ((out_alarm_r | out_sec_r) == '0))
    else $error("channel action reported during startup");

  // Active channels stay active until reset.
  a_active_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> ((active_r & $past(active_r)) == $past(active_r)))
    else $error("active channel bit cleared");

  // Write-back only happens during a scan and only to a real channel.
  a_wb_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    proc_vld_r |-> ((state_r == ST_SCAN) && (proc_idx_r <= LAST_CHAN)))
    else $error("memory write-back outside a channel scan");
`endif

endmodule
